// ===== hdl/hds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion stencil package
// Shared sizes, constants, codes and record types of the stencil step block.
// ----------------------------------------------------------------------------
package hds_pkg;

  // Grid limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Field widths
  localparam int unsigned DIM_W   = 11;  // grid_width / grid_height registers
  localparam int unsigned COEF_W  = 16;  // rx_coef / ry_coef, unsigned Q0.16
  localparam int unsigned VAL_W   = 32;  // cell value, signed Q16.16
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Derived widths
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);       // buffer address
  localparam int unsigned EFF_W  = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);  // row counter
  localparam int unsigned C0_W   = COEF_W + 3;              // 1 - 2rx - 2ry, signed
  localparam int unsigned TERM_W = VAL_W + 1;               // sum of two cells
  localparam int unsigned PROD_W = C0_W + TERM_W;
  localparam int unsigned ACC_W  = PROD_W + 2;

  // Stencil: centre, left+right, up+down
  localparam int unsigned N_TERMS = 3;

  // Constants 1.0 in Q0.16 and reset sizes
  localparam int unsigned ONE_Q16    = 1 << FRAC_W;
  localparam int unsigned GRID_W_RST = 1024;
  localparam int unsigned GRID_H_RST = 1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_RX_COEF     = 2'd2,
    CFG_RY_COEF     = 2'd3
  } cfg_idx_e;

  // Source of the left neighbour
  typedef enum logic [1:0] {
    LEFT_CENTER = 2'd0,
    LEFT_HOLD   = 2'd1,
    LEFT_PORT_B = 2'd2
  } left_src_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]         grid_width;
    logic [DIM_W-1:0]         grid_height;
    logic signed [C0_W-1:0]   c0;
    logic [COEF_W-1:0]        rx;
    logic [COEF_W-1:0]        ry;
  } cfg_t;

  // Record handed from cell to cell along the multiply-accumulate chain
  typedef struct packed {
    logic                             valid;
    logic                             last;
    logic signed [ACC_W-1:0]          acc;
    logic [N_TERMS-1:0][TERM_W-1:0]   term;
    logic [N_TERMS-1:0][C0_W-1:0]     coef;
  } slot_t;

endpackage

// ===== hdl/hds_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion stencil stream interfaces
// Valid/ready channels for grid samples in and updated cells out.
// ----------------------------------------------------------------------------
interface hds_in_if import hds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VAL_W-1:0] sample_value;

  modport source (output valid, output cmd, output sample_value, input ready);
  modport sink   (input valid, input cmd, input sample_value, output ready);
endinterface

interface hds_out_if import hds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] new_value;
  logic                    last;

  modport source (output valid, output new_value, output last, input ready);
  modport sink   (input valid, input new_value, input last, output ready);
endinterface

// ===== hdl/hds_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stencil front end
// Raster counters, the two line buffers and neighbour selection; loads the
// first record of the multiply-accumulate chain.
// ----------------------------------------------------------------------------
module hds_front import hds_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    en_i,
  input  logic                    accept_i,
  input  logic                    cmd_i,
  input  logic signed [VAL_W-1:0] sample_value_i,
  output slot_t                   slot_o
);

  // Line buffers: previous row (middle) and the one before it (above)
  logic [VAL_W-1:0] mid_mem   [MAX_WIDTH];
  logic [VAL_W-1:0] above_mem [MAX_WIDTH];

  // Counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] drn_q, drn_d;

  // Stage registers
  logic             s1_live_q;
  logic             s1_smp_q;
  logic             s1_emit_q;
  logic             s1_last_q;
  logic             s1_drain_q;
  left_src_e        s1_left_q;
  logic             s1_right_mid_q;
  logic             s1_up_mid_q;
  logic [COL_W-1:0] s1_pos_q;
  logic [VAL_W-1:0] s1_down_q;
  logic [VAL_W-1:0] rd_a_q;
  logic [VAL_W-1:0] rd_b_q;
  logic [VAL_W-1:0] up_q;
  logic [VAL_W-1:0] hold_q;

  // Decode
  logic [EFF_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] col_sel, drn_sel, pos, addr_b;
  logic             smp_ok, drn_ok, at_end;
  logic             emit, up_mid;
  left_src_e        left_src;
  logic             above_we, above_fwd;

  // Clamp the configured sizes
  always_comb begin
    if (cfg_i.grid_width == '0) begin
      w_eff = EFF_W'(1);
    end else if (32'(cfg_i.grid_width) > MAX_WIDTH) begin
      w_eff = EFF_W'(MAX_WIDTH);
    end else begin
      w_eff = EFF_W'(cfg_i.grid_width);
    end
    if (cfg_i.grid_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(cfg_i.grid_height) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(cfg_i.grid_height);
    end
  end

  // Position, buffer addresses and edge handling of the incoming transaction
  always_comb begin
    col_sel = (EFF_W'(col_q) >= w_eff) ? COL_W'(w_eff - EFF_W'(1)) : col_q;
    drn_sel = (EFF_W'(drn_q) >= w_eff) ? COL_W'(w_eff - EFF_W'(1)) : drn_q;
    smp_ok  = !cmd_i && (row_q < h_eff);
    drn_ok  = cmd_i && (row_q >= h_eff);
    pos     = cmd_i ? drn_sel : col_sel;
    at_end  = (EFF_W'(pos) + EFF_W'(1)) >= w_eff;
    // on the last drain column the right neighbour is the centre: reuse port B
    addr_b  = (cmd_i && at_end) ? pos - COL_W'(1) : pos + COL_W'(1);
    if (pos == '0) begin
      left_src = LEFT_CENTER;
    end else if (cmd_i && at_end) begin
      left_src = LEFT_PORT_B;
    end else begin
      left_src = LEFT_HOLD;
    end
    up_mid = cmd_i ? (h_eff == ROW_W'(1)) : (row_q == ROW_W'(1));
    emit   = cmd_i ? drn_ok : (smp_ok && (row_q != '0));
  end

  // Advance the raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    drn_d = drn_q;
    if (accept_i && smp_ok) begin
      if (at_end) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = pos + COL_W'(1);
      end
    end else if (accept_i && drn_ok) begin
      if (at_end) begin
        col_d = '0;
        row_d = '0;
        drn_d = '0;
      end else begin
        drn_d = pos + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      drn_q     <= '0;
      s1_live_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      drn_q <= drn_d;
      if (en_i) begin
        s1_live_q <= accept_i && (smp_ok || drn_ok);
      end
    end
  end

  // Capture the transaction's decode
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_smp_q       <= smp_ok;
      s1_emit_q      <= emit;
      s1_last_q      <= cmd_i && at_end;
      s1_drain_q     <= cmd_i;
      s1_left_q      <= left_src;
      s1_right_mid_q <= at_end;
      s1_up_mid_q    <= up_mid;
      s1_pos_q       <= pos;
      s1_down_q      <= sample_value_i;
    end
  end

  // Middle buffer: new sample written at once, two read ports
  always_ff @(posedge clk_i) begin
    if (accept_i && smp_ok) begin
      mid_mem[pos] <= sample_value_i;
    end
    if (accept_i) begin
      rd_a_q <= mid_mem[pos];
      rd_b_q <= mid_mem[addr_b];
    end
  end

  // Above buffer: old centre written as the record leaves, forward on a hit
  assign above_we  = en_i && s1_live_q && s1_smp_q;
  assign above_fwd = above_we && (s1_pos_q == pos);

  always_ff @(posedge clk_i) begin
    if (above_we) begin
      above_mem[s1_pos_q] <= rd_a_q;
    end
    if (accept_i) begin
      up_q <= above_fwd ? rd_a_q : above_mem[pos];
    end
  end

  // Hold the centre of the last record for the next left neighbour
  always_ff @(posedge clk_i) begin
    if (en_i && s1_live_q) begin
      hold_q <= rd_a_q;
    end
  end

  // Assemble the chain record
  logic signed [VAL_W-1:0]  mid_s, left_s, right_s, up_s, down_s;
  logic signed [TERM_W-1:0] lr_sum, ud_sum;

  always_comb begin
    mid_s = $signed(rd_a_q);
    case (s1_left_q)
      LEFT_CENTER: left_s = mid_s;
      LEFT_HOLD:   left_s = $signed(hold_q);
      LEFT_PORT_B: left_s = $signed(rd_b_q);
      default:     left_s = mid_s;
    endcase
    right_s = s1_right_mid_q ? mid_s : $signed(rd_b_q);
    up_s    = s1_up_mid_q ? mid_s : $signed(up_q);
    down_s  = s1_drain_q ? mid_s : $signed(s1_down_q);
    lr_sum  = TERM_W'(left_s) + TERM_W'(right_s);
    ud_sum  = TERM_W'(up_s) + TERM_W'(down_s);

    slot_o.valid   = s1_live_q && s1_emit_q;
    slot_o.last    = s1_last_q;
    slot_o.acc     = '0;
    slot_o.term[0] = TERM_W'(mid_s);
    slot_o.term[1] = lr_sum;
    slot_o.term[2] = ud_sum;
    slot_o.coef[0] = cfg_i.c0;
    slot_o.coef[1] = C0_W'(cfg_i.rx);
    slot_o.coef[2] = C0_W'(cfg_i.ry);
  end

endmodule

// ===== hdl/hds_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stencil multiply-accumulate cell
// Adds one coefficient-times-term product to the running sum and passes the
// remaining terms on to the next cell.
// ----------------------------------------------------------------------------
module hds_cell import hds_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  logic signed [PROD_W-1:0] prod;
  slot_t                    slot_d;
  slot_t                    slot_q;
  logic                     valid_q;

  // Consume the lowest term, shift the rest down
  always_comb begin
    prod        = $signed(slot_i.coef[0]) * $signed(slot_i.term[0]);
    slot_d      = slot_i;
    slot_d.acc  = slot_i.acc + ACC_W'(prod);
    slot_d.term = slot_i.term >> TERM_W;
    slot_d.coef = slot_i.coef >> C0_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && slot_i.valid) begin
      slot_q <= slot_d;
    end
  end

  always_comb begin
    slot_o       = slot_q;
    slot_o.valid = valid_q;
  end

endmodule

// ===== hdl/hds_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stencil output stage
// Rounds and saturates the finished sum, then drives the result channel
// through an output register and a skid entry.
// ----------------------------------------------------------------------------
module hds_out import hds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slot_t            slot_i,
  output logic             en_o,
  hds_out_if.source        out_o
);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] VAL_MAX  =
    $signed({{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] VAL_MIN  =
    $signed({{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic             last;
  } res_t;

  logic signed [ACC_W-1:0] biased, shifted;
  res_t                    res;
  res_t                    out_q, skid_q;
  logic                    out_v_q, skid_v_q;
  logic                    take;

  // Round to nearest, ties up, then saturate
  always_comb begin
    biased  = slot_i.acc + RND_HALF;
    shifted = biased >>> FRAC_W;
    if (shifted > VAL_MAX) begin
      res.new_value = VAL_MAX[VAL_W-1:0];
    end else if (shifted < VAL_MIN) begin
      res.new_value = VAL_MIN[VAL_W-1:0];
    end else begin
      res.new_value = shifted[VAL_W-1:0];
    end
    res.last = slot_i.last;
  end

  assign take = out_o.ready || !out_v_q;
  assign en_o = !skid_v_q;

  // Output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= slot_i.valid;
      end
    end else if (slot_i.valid && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (slot_i.valid) begin
        out_q <= res;
      end
    end else if (slot_i.valid && !skid_v_q) begin
      skid_q <= res;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.new_value = $signed(out_q.new_value);
  assign out_o.last      = out_q.last;

endmodule

// ===== hdl/heat_diffusion_stencil_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion stencil step
// One explicit time step of the 2D heat equation, five-point stencil with
// edge copy, on a grid streamed in raster order.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+-------------------------------------
//  cfg     | in        | cfg_we_i         | cfg_idx_i, cfg_data_i[15:0]
//  in_i    | in        | valid / ready    | cmd, sample_value (Q16.16)
//  out_o   | out       | valid / ready    | new_value (Q16.16), last
//
//  One transaction per cycle in and out while out_o takes results. A result
//  follows the sample that completes its neighbourhood through a line-buffer
//  read stage, three multiply-accumulate cells and the rounding output register.
//  Reset clears counters, valid bits and the configuration registers; the line
//  buffers hold nothing defined until written and there is no clearing pass.
//  in_i.ready drops only while the skid entry is full, i.e. when a result has
//  been refused on out_o.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step import hds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hds_in_if.sink                in_i,
  hds_out_if.source             out_o
);

  logic [DIM_W-1:0]  grid_width_q;
  logic [DIM_W-1:0]  grid_height_q;
  logic [COEF_W-1:0] rx_coef_q;
  logic [COEF_W-1:0] ry_coef_q;
  cfg_t              cfg;
  logic              en;
  logic              accept;
  slot_t             chain [N_TERMS+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_W'(GRID_W_RST);
      grid_height_q <= DIM_W'(GRID_H_RST);
      rx_coef_q     <= '0;
      ry_coef_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_RX_COEF:     rx_coef_q     <= cfg_data_i[COEF_W-1:0];
        CFG_RY_COEF:     ry_coef_q     <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Centre weight 1 - 2rx - 2ry
  always_comb begin
    cfg.grid_width  = grid_width_q;
    cfg.grid_height = grid_height_q;
    cfg.rx          = rx_coef_q;
    cfg.ry          = ry_coef_q;
    cfg.c0          = C0_W'(ONE_Q16) - (C0_W'(rx_coef_q) << 1)
                      - (C0_W'(ry_coef_q) << 1);
  end

  assign in_i.ready = en;
  assign accept     = in_i.valid && en;

  hds_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .en_i           (en),
    .accept_i       (accept),
    .cmd_i          (in_i.cmd),
    .sample_value_i (in_i.sample_value),
    .slot_o         (chain[0])
  );

  // Multiply-accumulate chain
  for (genvar k = 0; k < N_TERMS; k++) begin : g_cell
    hds_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .slot_i (chain[k]),
      .slot_o (chain[k+1])
    );
  end

  hds_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .slot_i (chain[N_TERMS]),
    .en_o   (en),
    .out_o  (out_o)
  );

endmodule

// ===== hdl/hds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat diffusion stencil port properties
// Watches the stream ports of the stencil step and flags handshake and
// back-pressure slips.
// ----------------------------------------------------------------------------
module hds_props import hds_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [VAL_W-1:0] out_new_value_i,
  input logic                    out_last_i
);

  // Hold a refused result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_new_value_i)
                                     && $stable(out_last_i))
    else $error("refused result changed or dropped");

  // Back-pressure only follows a refused result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without a refused result");

  // A stalled input implies a result is waiting
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled while no result is shown");

  // Idle and open during reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i && in_ready_i)
    else $error("ports not idle during reset");

endmodule

bind heat_diffusion_stencil_step hds_props u_hds_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_new_value_i (out_o.new_value),
  .out_last_i      (out_o.last)
);
